### hw/rtl/ufd_pkg.sv
// Package with the shared types, codes and reset values of the UART frame decoder.
package ufd_pkg;

	// Field widths of the stream items.
	localparam int unsigned SAMPLE_FIELD_W = 32;
	localparam int unsigned DATA_W         = 9;
	localparam int unsigned MEASURE_W      = 4;
	localparam int unsigned KIND_W         = 3;
	localparam int unsigned IN_TDATA_W     = 72;
	localparam int unsigned OUT_TDATA_W    = 80;

	// Default width of the sample index counter of the bit source.
	localparam int unsigned SAMPLE_INDEX_WIDTH_DEF = 32;

	// Configuration port geometry.
	localparam int unsigned APB_ADDR_W = 5;
	localparam int unsigned APB_DATA_W = 32;

	// Register indexes (byte address is four times the index).
	typedef enum logic [2:0] {
		REG_DATA_BITS   = 3'd0,
		REG_LSB_FIRST   = 3'd1,
		REG_PARITY_MODE = 3'd2,
		REG_STOP_MODE   = 3'd3,
		REG_INVERT_LINE = 3'd4
	} reg_index_t;

	// Event kinds reported on the output stream.
	typedef enum logic [2:0] {
		EV_START      = 3'd0,
		EV_START_ERR  = 3'd1,
		EV_DATA       = 3'd2,
		EV_PARITY_OK  = 3'd3,
		EV_PARITY_ERR = 3'd4,
		EV_STOP       = 3'd5,
		EV_STOP_ERR   = 3'd6
	} ev_kind_t;

	// Parity mode codes.
	localparam logic [2:0] PAR_NONE = 3'd0;
	localparam logic [2:0] PAR_ODD  = 3'd1;
	localparam logic [2:0] PAR_EVEN = 3'd2;
	localparam logic [2:0] PAR_ZERO = 3'd3;
	localparam logic [2:0] PAR_ONE  = 3'd4;

	// Stop mode codes.
	localparam logic [2:0] STOP_NONE      = 3'd0;
	localparam logic [2:0] STOP_HALF      = 3'd1;
	localparam logic [2:0] STOP_ONE       = 3'd2;
	localparam logic [2:0] STOP_ONE_HALF  = 3'd3;
	localparam logic [2:0] STOP_TWO       = 3'd4;

	// Register reset values.
	localparam logic [3:0] DATA_BITS_RST   = 4'd8;
	localparam logic       LSB_FIRST_RST   = 1'b1;
	localparam logic [2:0] PARITY_MODE_RST = PAR_NONE;
	localparam logic [2:0] STOP_MODE_RST   = STOP_ONE;
	localparam logic       INVERT_RST      = 1'b0;

	// Data width limits.
	localparam logic [3:0] DATA_BITS_MIN = 4'd5;
	localparam logic [3:0] DATA_BITS_MAX = 4'd9;

endpackage

### hw/rtl/uart_frame_decoder.sv
// UART frame decoder top level: walks pre-sampled line bits and reports frame events.
//
// The decoder accepts one line bit (or one half-bit in the stop phase of the half
// stop modes) per clock on the s_ stream and reports at most one frame event per bit on
// the m_ stream. An accepted item sits in an input register while the frame state
// machine decodes it, and the event is then loaded into the output register that
// drives m_tdata. The sustained rate is one item per clock; only an output register
// that is not being drained holds back items that produce an event, while items that
// produce none pass on regardless.
// The user is to write configuration through the APB port while the stream is idle;
// this is not enforced; registers changed mid-frame take effect on the next bit.
module uart_frame_decoder #(
	parameter int unsigned SAMPLE_INDEX_WIDTH = ufd_pkg::SAMPLE_INDEX_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Input stream: [0] bit_value, [32:1] bit_first_sample, [64:33] bit_last_sample,
	// [71:65] zero fill.
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [ufd_pkg::IN_TDATA_W-1:0]        s_tdata,
	// Output stream: [2:0] event_kind, [11:3] data_value, [15:12] measure,
	// [47:16] span_start, [79:48] span_length.
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [ufd_pkg::OUT_TDATA_W-1:0]       m_tdata,
	// Configuration port.
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [ufd_pkg::APB_ADDR_W-1:0]        paddr,
	input  logic [ufd_pkg::APB_DATA_W-1:0]        pwdata,
	output logic [ufd_pkg::APB_DATA_W-1:0]        prdata,
	output logic                                  pready
);

	// Sample indexes are kept at the width of the source counter, at most the field width.
	localparam int unsigned SPAN_W = (SAMPLE_INDEX_WIDTH < ufd_pkg::SAMPLE_FIELD_W) ?
		SAMPLE_INDEX_WIDTH : ufd_pkg::SAMPLE_FIELD_W;

	typedef enum logic [1:0] {
		PH_START,
		PH_DATA,
		PH_PARITY,
		PH_STOP
	} phase_t;

	// Configuration registers.
	logic [3:0] data_bits_q;
	logic       lsb_first_q;
	logic [2:0] parity_mode_q;
	logic [2:0] stop_mode_q;
	logic       invert_line_q;

	ufd_pkg::reg_index_t reg_idx;
	logic                cfg_write;

	assign pready    = 1'b1;
	assign reg_idx   = ufd_pkg::reg_index_t'(paddr[4:2]);
	assign cfg_write = psel && penable && pwrite && pready;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_bits_q   <= ufd_pkg::DATA_BITS_RST;
			lsb_first_q   <= ufd_pkg::LSB_FIRST_RST;
			parity_mode_q <= ufd_pkg::PARITY_MODE_RST;
			stop_mode_q   <= ufd_pkg::STOP_MODE_RST;
			invert_line_q <= ufd_pkg::INVERT_RST;
		end else if (cfg_write) begin
			case (reg_idx)
				ufd_pkg::REG_DATA_BITS:   data_bits_q   <= pwdata[3:0];
				ufd_pkg::REG_LSB_FIRST:   lsb_first_q   <= pwdata[0];
				ufd_pkg::REG_PARITY_MODE: parity_mode_q <= pwdata[2:0];
				ufd_pkg::REG_STOP_MODE:   stop_mode_q   <= pwdata[2:0];
				ufd_pkg::REG_INVERT_LINE: invert_line_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Register reads.
	always_comb begin
		prdata = '0;
		case (reg_idx)
			ufd_pkg::REG_DATA_BITS:   prdata = ufd_pkg::APB_DATA_W'(data_bits_q);
			ufd_pkg::REG_LSB_FIRST:   prdata = ufd_pkg::APB_DATA_W'(lsb_first_q);
			ufd_pkg::REG_PARITY_MODE: prdata = ufd_pkg::APB_DATA_W'(parity_mode_q);
			ufd_pkg::REG_STOP_MODE:   prdata = ufd_pkg::APB_DATA_W'(stop_mode_q);
			ufd_pkg::REG_INVERT_LINE: prdata = ufd_pkg::APB_DATA_W'(invert_line_q);
			default:                  prdata = '0;
		endcase
	end

	// Input register.
	logic              valid_s1;
	logic              bit_s1;
	logic [SPAN_W-1:0] first_s1;
	logic [SPAN_W-1:0] last_s1;
	logic              advance;
	logic              has_result;

	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			bit_s1   <= s_tdata[0];
			first_s1 <= s_tdata[SPAN_W:1];
			last_s1  <= s_tdata[33 +: SPAN_W];
		end
	end

	// Frame state.
	phase_t            phase_q;
	logic [8:0]        shift_q;
	logic [3:0]        data_cnt_q;
	logic [1:0]        stop_cnt_q;
	logic [SPAN_W-1:0] data_begin_q;
	logic [SPAN_W-1:0] stop_begin_q;

	// Output register.
	logic                     out_valid_q;
	ufd_pkg::ev_kind_t        out_kind_q;
	logic [8:0]               out_data_q;
	logic [3:0]               out_measure_q;
	logic [SPAN_W-1:0]        out_start_q;
	logic [SPAN_W-1:0]        out_length_q;

	// Effective settings with out-of-range codes folded.
	logic [3:0] width_n;
	logic [8:0] width_mask;
	logic [2:0] parity_eff;
	logic [2:0] stop_eff;
	logic       line_bit;

	always_comb begin
		if (data_bits_q < ufd_pkg::DATA_BITS_MIN) begin
			width_n = ufd_pkg::DATA_BITS_MIN;
		end else if (data_bits_q > ufd_pkg::DATA_BITS_MAX) begin
			width_n = ufd_pkg::DATA_BITS_MAX;
		end else begin
			width_n = data_bits_q;
		end
		width_mask = 9'((10'd1 << width_n) - 10'd1);
		parity_eff = (parity_mode_q > ufd_pkg::PAR_ONE) ? ufd_pkg::PAR_NONE : parity_mode_q;
		stop_eff   = (stop_mode_q > ufd_pkg::STOP_TWO) ? ufd_pkg::STOP_ONE : stop_mode_q;
		line_bit   = bit_s1 ^ invert_line_q;
	end

	// Decode of the item in the input register.
	phase_t            phase_d;
	logic [8:0]        shift_d;
	logic [3:0]        data_cnt_d;
	logic [1:0]        stop_cnt_d;
	logic [SPAN_W-1:0] data_begin_d;
	logic [SPAN_W-1:0] stop_begin_d;
	ufd_pkg::ev_kind_t ev_kind;
	logic [8:0]        ev_data;
	logic [3:0]        ev_measure;
	logic [SPAN_W-1:0] ev_start;
	logic [8:0]        shifted;
	logic              ones_odd;
	logic              par_ok;
	logic [1:0]        stop_items;
	logic [3:0]        stop_halves;

	always_comb begin
		phase_d      = phase_q;
		shift_d      = shift_q;
		data_cnt_d   = data_cnt_q;
		stop_cnt_d   = stop_cnt_q;
		data_begin_d = data_begin_q;
		stop_begin_d = stop_begin_q;
		has_result   = 1'b0;
		ev_kind      = ufd_pkg::EV_START;
		ev_data      = '0;
		ev_measure   = '0;
		ev_start     = first_s1;

		// Data word with this bit shifted in, kept to the current width.
		if (lsb_first_q) begin
			shifted = ((shift_q >> 1) | (9'(line_bit) << (width_n - 4'd1))) & width_mask;
		end else begin
			shifted = ((shift_q << 1) | 9'(line_bit)) & width_mask;
		end

		// Parity over the stored data bits and the parity bit.
		ones_odd = (^(shift_q & width_mask)) ^ line_bit;
		unique case (parity_eff)
			ufd_pkg::PAR_ODD:  par_ok = ones_odd;
			ufd_pkg::PAR_EVEN: par_ok = !ones_odd;
			ufd_pkg::PAR_ZERO: par_ok = !line_bit;
			ufd_pkg::PAR_ONE:  par_ok = line_bit;
			default:           par_ok = 1'b0;
		endcase

		// Stop items expected and reported length in half bits.
		unique case (stop_eff)
			ufd_pkg::STOP_HALF:     begin stop_items = 2'd1; stop_halves = 4'd1; end
			ufd_pkg::STOP_ONE_HALF: begin stop_items = 2'd3; stop_halves = 4'd3; end
			ufd_pkg::STOP_TWO:      begin stop_items = 2'd2; stop_halves = 4'd4; end
			default:                begin stop_items = 2'd1; stop_halves = 4'd2; end
		endcase

		unique case (phase_q)
			PH_START: begin
				has_result = 1'b1;
				if (line_bit) begin
					ev_kind = ufd_pkg::EV_START_ERR;
				end else begin
					ev_kind    = ufd_pkg::EV_START;
					shift_d    = '0;
					data_cnt_d = '0;
					phase_d    = PH_DATA;
				end
			end
			PH_DATA: begin
				if (data_cnt_q == 4'd0) begin
					data_begin_d = first_s1;
				end
				shift_d = shifted;
				if (data_cnt_q < width_n - 4'd1) begin
					data_cnt_d = data_cnt_q + 4'd1;
				end else begin
					has_result = 1'b1;
					ev_kind    = ufd_pkg::EV_DATA;
					ev_data    = shifted;
					ev_measure = data_cnt_q + 4'd1;
					ev_start   = data_begin_d;
					data_cnt_d = '0;
					stop_cnt_d = '0;
					if (parity_eff == ufd_pkg::PAR_NONE) begin
						phase_d = (stop_eff == ufd_pkg::STOP_NONE) ? PH_START : PH_STOP;
					end else begin
						phase_d = PH_PARITY;
					end
				end
			end
			PH_PARITY: begin
				has_result = 1'b1;
				ev_kind    = par_ok ? ufd_pkg::EV_PARITY_OK : ufd_pkg::EV_PARITY_ERR;
				ev_measure = 4'd1;
				stop_cnt_d = '0;
				phase_d    = (stop_eff == ufd_pkg::STOP_NONE) ? PH_START : PH_STOP;
			end
			PH_STOP: begin
				if (stop_eff == ufd_pkg::STOP_NONE) begin
					// Stop bits were switched off mid-frame: drop back silently.
					phase_d = PH_START;
				end else begin
					if (stop_cnt_q == 2'd0) begin
						stop_begin_d = first_s1;
					end
					ev_start = stop_begin_d;
					if (!line_bit) begin
						has_result = 1'b1;
						ev_kind    = ufd_pkg::EV_STOP_ERR;
						ev_measure = 4'd1;
						stop_cnt_d = '0;
						phase_d    = PH_START;
					end else if (stop_cnt_q < stop_items - 2'd1) begin
						stop_cnt_d = stop_cnt_q + 2'd1;
					end else begin
						has_result = 1'b1;
						ev_kind    = ufd_pkg::EV_STOP;
						ev_measure = stop_halves;
						stop_cnt_d = '0;
						phase_d    = PH_START;
					end
				end
			end
			default: phase_d = PH_START;
		endcase
	end

	assign advance = valid_s1 && (!has_result || !out_valid_q || m_tready);

	// Frame state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_START;
			shift_q      <= '0;
			data_cnt_q   <= '0;
			stop_cnt_q   <= '0;
			data_begin_q <= '0;
			stop_begin_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (advance) begin
				phase_q      <= phase_d;
				shift_q      <= shift_d;
				data_cnt_q   <= data_cnt_d;
				stop_cnt_q   <= stop_cnt_d;
				data_begin_q <= data_begin_d;
				stop_begin_q <= stop_begin_d;
			end
			if (advance && has_result) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			out_kind_q    <= ev_kind;
			out_data_q    <= ev_data;
			out_measure_q <= ev_measure;
			out_start_q   <= ev_start;
			out_length_q  <= last_s1 - ev_start;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {
		ufd_pkg::SAMPLE_FIELD_W'(out_length_q),
		ufd_pkg::SAMPLE_FIELD_W'(out_start_q),
		out_measure_q,
		out_data_q,
		out_kind_q
	};

endmodule

### hw/rtl/ufd_checker.sv
// Port-level checker for the UART frame decoder, bound to the top level.
module ufd_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_tready,
	input logic                               m_tvalid,
	input logic                               m_tready,
	input logic [ufd_pkg::OUT_TDATA_W-1:0]    m_tdata
);

	logic [2:0] kind;
	logic [8:0] data_value;
	logic [3:0] measure;

	assign kind       = m_tdata[2:0];
	assign data_value = m_tdata[11:3];
	assign measure    = m_tdata[15:12];

	// A stalled event holds its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output event changed while stalled");

	// The input side only stalls behind a pending event.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no pending event");

	// Only data events carry a data word.
	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && kind != ufd_pkg::EV_DATA |-> data_value == 9'd0)
		else $error("non-data event carries a data word");

	// Start events carry no measure.
	a_start_meas: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (kind == ufd_pkg::EV_START || kind == ufd_pkg::EV_START_ERR)
		|-> measure == 4'd0)
		else $error("start event with a measure");

	// A stop event lasts one to four half bits.
	a_stop_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && kind == ufd_pkg::EV_STOP
		|-> measure == 4'd1 || measure == 4'd2 || measure == 4'd3 || measure == 4'd4)
		else $error("stop event with a bad length");

endmodule

bind uart_frame_decoder ufd_checker u_ufd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
